>>> rtl/crc_pkg.sv
// Shared types, field widths and constants of the capability relation checker.
package crc_pkg;

    localparam int unsigned FIELD_W     = 54;
    localparam int unsigned TAG_W       = 32;
    localparam int unsigned BITS_W      = 8;
    localparam int unsigned ADDR_W      = 64;
    localparam int unsigned MASK_W      = 8;
    localparam int unsigned TYPE_W      = 3;

    localparam int unsigned TAG_SHIFT_DEF   = 27;
    localparam int unsigned BLOCK_SHIFT_DEF = 12;

    localparam int unsigned TDATA_IN_W  = 408;
    localparam int unsigned TUSER_IN_W  = 2 * TYPE_W;
    localparam int unsigned TDATA_OUT_W = 8;

    localparam logic [MASK_W-1:0] PERM_MASK_RST = 8'd15;
    localparam logic [MASK_W-1:0] MODE_MASK_RST = 8'd3;

    typedef enum logic [0:0] {
        CFG_SOCKET_PERM = 1'b0,
        CFG_SOCKET_MODE = 1'b1
    } t_cfg_index;

    typedef enum logic [TYPE_W-1:0] {
        CAP_NONE    = 3'd0,
        CAP_TIME    = 3'd1,
        CAP_MEMORY  = 3'd2,
        CAP_PMP     = 3'd3,
        CAP_MONITOR = 3'd4,
        CAP_CHANNEL = 3'd5,
        CAP_SOCKET  = 3'd6,
        CAP_PATH    = 3'd7
    } t_cap_type;

    // Generic fields of one capability, low field in the lowest bits.
    typedef struct packed {
        logic [BITS_W-1:0]  bits;
        logic [TAG_W-1:0]   tag;
        logic [FIELD_W-1:0] high;
        logic [FIELD_W-1:0] mark;
        logic [FIELD_W-1:0] low;
    } t_cap_data;

    typedef struct packed {
        t_cap_type p_type;
        t_cap_type c_type;
        t_cap_data p;
        t_cap_data c;
    } t_pair;

    // Composed byte addresses of the parent and the decoded child PMP region.
    typedef struct packed {
        logic [ADDR_W-1:0] p_lo_addr;
        logic [ADDR_W-1:0] p_mk_addr;
        logic [ADDR_W-1:0] p_hi_addr;
        logic [ADDR_W-1:0] c_base;
        logic [ADDR_W-1:0] c_end;
    } t_addr_set;

    typedef struct packed {
        logic [MASK_W-1:0] perm_mask;
        logic [MASK_W-1:0] mode_mask;
    } t_sock_cfg;

    typedef struct packed {
        logic child_valid;
        logic derivable;
        logic revokable;
    } t_flags;

endpackage

>>> rtl/crc_addr.sv
// Address stage: composes parent memory addresses and decodes the child NAPOT region.
module crc_addr #(
    parameter int unsigned TAG_SHIFT   = crc_pkg::TAG_SHIFT_DEF,
    parameter int unsigned BLOCK_SHIFT = crc_pkg::BLOCK_SHIFT_DEF
) (
    input  crc_pkg::t_pair     i_pair,
    output crc_pkg::t_addr_set o_addr
);
    import crc_pkg::*;

    logic [ADDR_W-1:0] napot_a;
    logic [ADDR_W-1:0] napot_a1;

    // Byte address of a block within a tagged region, wrapping at the address width.
    function automatic logic [ADDR_W-1:0] compose(input logic [TAG_W-1:0] tag,
                                                  input logic [FIELD_W-1:0] blk);
        logic [ADDR_W-1:0] tag_part;
        logic [ADDR_W-1:0] blk_part;
        tag_part = ADDR_W'(tag) << TAG_SHIFT;
        blk_part = ADDR_W'(blk) << BLOCK_SHIFT;
        return tag_part + blk_part;
    endfunction

    assign napot_a  = ADDR_W'(i_pair.c.low);
    assign napot_a1 = napot_a + ADDR_W'(1);

    always_comb begin
        o_addr.p_lo_addr = compose(i_pair.p.tag, i_pair.p.low);
        o_addr.p_mk_addr = compose(i_pair.p.tag, i_pair.p.mark);
        o_addr.p_hi_addr = compose(i_pair.p.tag, i_pair.p.high);
        // Trailing ones select the region size; the base keeps the bits above them.
        o_addr.c_base    = (napot_a1 & napot_a) << 2;
        o_addr.c_end     = ((napot_a1 | napot_a) + ADDR_W'(1)) << 2;
    end

endmodule

>>> rtl/crc_rules.sv
// Rule stage: range, permission and per-type validity checks that yield the three flags.
module crc_rules (
    input  crc_pkg::t_pair     i_pair,
    input  crc_pkg::t_addr_set i_addr,
    input  crc_pkg::t_sock_cfg i_cfg,
    output crc_pkg::t_flags    o_flags
);
    import crc_pkg::*;

    logic same_tag;
    logic p_tag_zero;
    logic c_tag_zero;
    logic bits_sub;
    logic lo_in;
    logic mk_in;
    logic hi_in;
    logic sock_lo_in;
    logic sock_mk_in;
    logic pmp_rev_in;
    logic pmp_der_in;
    logic same_chan;
    logic valid_range;
    logic valid_pmp;
    logic valid_sock;
    logic valid_child;

    always_comb begin
        same_tag    = i_pair.p.tag == i_pair.c.tag;
        p_tag_zero  = i_pair.p.tag == '0;
        c_tag_zero  = i_pair.c.tag == '0;
        bits_sub    = (i_pair.c.bits & ~i_pair.p.bits) == '0;
        lo_in       = i_pair.p.low  <= i_pair.c.low;
        mk_in       = i_pair.p.mark <= i_pair.c.low;
        hi_in       = i_pair.c.high <= i_pair.p.high;
        // A socket covers the single channel at its low field.
        sock_lo_in  = lo_in && (i_pair.c.low < i_pair.p.high);
        sock_mk_in  = mk_in && (i_pair.c.low < i_pair.p.high);
        pmp_rev_in  = (i_addr.p_lo_addr <= i_addr.c_base) && (i_addr.c_end <= i_addr.p_hi_addr);
        pmp_der_in  = (i_addr.p_mk_addr <= i_addr.c_base) && (i_addr.c_end <= i_addr.p_hi_addr);
        same_chan   = i_pair.p.low == i_pair.c.low;
        valid_range = (i_pair.c.low == i_pair.c.mark) && (i_pair.c.low < i_pair.c.high);
        valid_pmp   = (i_pair.c.mark == '0) && (i_pair.c.high == '0);
        valid_sock  = ((i_pair.c.bits & ~i_cfg.perm_mask) == '0)
                   && ((i_pair.c.mark & ~FIELD_W'(i_cfg.mode_mask)) == '0);
    end

    always_comb begin
        o_flags.revokable   = 1'b0;
        o_flags.derivable   = 1'b0;
        o_flags.child_valid = valid_child;
        case (i_pair.p_type)
            CAP_TIME: begin
                o_flags.revokable = (i_pair.c_type == CAP_TIME) && same_tag && lo_in && hi_in;
                o_flags.derivable = (i_pair.c_type == CAP_TIME) && same_tag
                                 && (i_pair.p.mark == i_pair.c.low) && hi_in;
            end
            CAP_MONITOR: begin
                o_flags.revokable = (i_pair.c_type == CAP_MONITOR) && lo_in && hi_in;
                o_flags.derivable = (i_pair.c_type == CAP_MONITOR) && mk_in && hi_in;
            end
            CAP_MEMORY: begin
                if (i_pair.c_type == CAP_PMP) begin
                    o_flags.revokable = pmp_rev_in;
                    o_flags.derivable = pmp_der_in && bits_sub;
                end else begin
                    o_flags.revokable = (i_pair.c_type == CAP_MEMORY) && same_tag
                                     && lo_in && hi_in;
                    o_flags.derivable = (i_pair.c_type == CAP_MEMORY) && same_tag
                                     && mk_in && hi_in && bits_sub;
                end
            end
            CAP_CHANNEL: begin
                if (i_pair.c_type == CAP_SOCKET) begin
                    o_flags.revokable = sock_lo_in;
                    o_flags.derivable = c_tag_zero && sock_mk_in;
                end else begin
                    o_flags.revokable = (i_pair.c_type == CAP_CHANNEL) && lo_in && hi_in;
                    o_flags.derivable = (i_pair.c_type == CAP_CHANNEL) && mk_in && hi_in;
                end
            end
            CAP_SOCKET: begin
                // Revocation of a socket does not look at the child's type code.
                o_flags.revokable = p_tag_zero && !c_tag_zero && same_chan;
                o_flags.derivable = (i_pair.c_type == CAP_SOCKET) && same_chan && p_tag_zero
                                 && !c_tag_zero && (i_pair.p.mark == i_pair.c.mark)
                                 && (i_pair.p.bits == i_pair.c.bits);
            end
            default: begin
                o_flags.revokable = 1'b0;
                o_flags.derivable = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (i_pair.c_type)
            CAP_TIME, CAP_MEMORY, CAP_MONITOR, CAP_CHANNEL: valid_child = valid_range;
            CAP_PMP:                                        valid_child = valid_pmp;
            CAP_SOCKET:                                     valid_child = valid_sock;
            default:                                        valid_child = 1'b0;
        endcase
    end

endmodule

>>> rtl/capability_relation_check_top.sv
// Top level of the capability relation checker: handshake, pipeline registers and configuration.
// A pair passes the input, address and result registers in that order before its flags are shown.
// Throughput: one pair per cycle while m_axis_tready is high; the three register stages (input,
// address, result) each advance whenever the stage after them is empty or is being emptied.
// Reset (i_rst_n low at a clock edge) empties all stages and loads the socket masks with
// their defaults, permission 0x0F and mode 0x03.
module capability_relation_check_top #(
    parameter int unsigned TAG_SHIFT   = crc_pkg::TAG_SHIFT_DEF,
    parameter int unsigned BLOCK_SHIFT = crc_pkg::BLOCK_SHIFT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // Slave side: one parent/child pair per transfer.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata from bit 0 up: parent_low, parent_mark, parent_high, parent_tag, parent_bits,
    // child_low, child_mark, child_high, child_tag, child_bits, zero fill.
    input  logic [crc_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    // tuser from bit 0 up: parent_type, child_type.
    input  logic [crc_pkg::TUSER_IN_W-1:0]  s_axis_tuser,

    // Master side: one set of flags per transfer.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata from bit 0 up: revokable, derivable, child_valid, zero fill.
    output logic [crc_pkg::TDATA_OUT_W-1:0] m_axis_tdata,

    // Configuration writes; the user must give them only while the block is idle (not enforced).
    input  logic                             i_cfg_we,
    input  logic [0:0]                       i_cfg_idx,
    input  logic [crc_pkg::MASK_W-1:0]      i_cfg_data
);
    import crc_pkg::*;

    localparam int unsigned CAP_W = $bits(t_cap_data);

    // Stage registers and their valid bits.
    t_pair       r_in;
    logic        r_in_v;
    t_pair       r_mid_pair;
    t_addr_set   r_mid_addr;
    logic        r_mid_v;
    t_flags      r_out;
    logic        r_out_v;

    // Socket masks.
    t_sock_cfg   r_cfg;

    t_pair       n_in;
    t_addr_set   addr_set;
    t_flags      flags;
    logic        in_ready;
    logic        mid_ready;
    logic        out_ready;

    // A stage takes new contents when it is empty or its contents move on in the same cycle.
    assign out_ready     = !r_out_v || m_axis_tready;
    assign mid_ready     = !r_mid_v || out_ready;
    assign in_ready      = !r_in_v  || mid_ready;
    assign s_axis_tready = in_ready;

    always_comb begin
        n_in.p_type = t_cap_type'(s_axis_tuser[TYPE_W-1:0]);
        n_in.c_type = t_cap_type'(s_axis_tuser[2*TYPE_W-1:TYPE_W]);
        n_in.p      = t_cap_data'(s_axis_tdata[CAP_W-1:0]);
        n_in.c      = t_cap_data'(s_axis_tdata[2*CAP_W-1:CAP_W]);
    end

    crc_addr #(
        .TAG_SHIFT   (TAG_SHIFT),
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) u_addr (
        .i_pair (r_in),
        .o_addr (addr_set)
    );

    crc_rules u_rules (
        .i_pair  (r_mid_pair),
        .i_addr  (r_mid_addr),
        .i_cfg   (r_cfg),
        .o_flags (flags)
    );

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mid_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_v <= s_axis_tvalid;
            end
            if (mid_ready) begin
                r_mid_v <= r_in_v;
            end
            if (out_ready) begin
                r_out_v <= r_mid_v;
            end
        end
    end

    // Payload of the stages; it needs no reset since the valid bits qualify it.
    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_in <= n_in;
        end
        if (mid_ready && r_in_v) begin
            r_mid_pair <= r_in;
            r_mid_addr <= addr_set;
        end
        if (out_ready && r_mid_v) begin
            r_out <= flags;
        end
    end

    // Configuration registers; the user must write them only while no pair is in flight (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.perm_mask <= PERM_MASK_RST;
            r_cfg.mode_mask <= MODE_MASK_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_idx))
                CFG_SOCKET_PERM: r_cfg.perm_mask <= i_cfg_data;
                CFG_SOCKET_MODE: r_cfg.mode_mask <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = TDATA_OUT_W'(r_out);

endmodule

>>> tb/cap_relation_monitor.sv
// Checker that predicts the relation flags of each accepted capability pair and compares them.
`timescale 1ns / 1ps

module cap_relation_monitor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // Fields from bit 0 up: parent low, mark, high, tag, bits, then the same for the child.
    input  logic [crc_pkg::TDATA_IN_W-1:0]   i_s_tdata,
    // Fields from bit 0 up: parent_type, child_type.
    input  logic [crc_pkg::TUSER_IN_W-1:0]   i_s_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // Fields from bit 0 up: revokable, derivable, child_valid.
    input  logic [crc_pkg::TDATA_OUT_W-1:0]  i_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [0:0]                       i_cfg_idx,
    input  logic [crc_pkg::MASK_W-1:0]       i_cfg_data,
    output int                               o_pending,
    output int                               o_errors
);
    import crc_pkg::*;

    localparam int unsigned CAP_W = $bits(t_cap_data);

    t_flags            flags_due[$];
    logic [MASK_W-1:0] perm_mask;
    logic [MASK_W-1:0] mode_mask;
    int                err_count = 0;
    int                result_no = 0;
    string             flag_name[3] = '{"revokable", "derivable", "child_valid"};

    assign o_errors = err_count;

    // The outer range holds the inner one; all bounds are 64-bit byte or unit addresses.
    function automatic logic spans(input logic [63:0] ob, input logic [63:0] oe,
                                   input logic [63:0] ib, input logic [63:0] ie);
        return ob <= ib && ie <= oe;
    endfunction

    function automatic logic subset(input logic [63:0] sub, input logic [63:0] sup);
        return (sub & sup) == sub;
    endfunction

    // Byte address of a memory block; wraps modulo 2^64 like the hardware adder.
    function automatic logic [63:0] byte_addr(input logic [TAG_W-1:0] tg,
                                              input logic [FIELD_W-1:0] blk);
        return (64'(tg) << TAG_SHIFT_DEF) + (64'(blk) << BLOCK_SHIFT_DEF);
    endfunction

    function automatic t_flags relation_flags(input t_cap_type pt, input t_cap_type ct,
                                              input t_cap_data p, input t_cap_data c,
                                              input logic [MASK_W-1:0] perm_m,
                                              input logic [MASK_W-1:0] mode_m);
        logic [63:0] a;
        logic [63:0] pmp_base;
        logic [63:0] pmp_end;
        logic [63:0] chan_end;
        t_flags      f;
        // NAPOT decode of the child address: the trailing ones give the region size.
        a        = 64'(c.low);
        pmp_base = ((a + 64'd1) & a) << 2;
        pmp_end  = pmp_base + ((((a + 64'd1) ^ a) + 64'd1) << 2);
        // A socket occupies exactly one channel.
        chan_end = 64'(c.low) + 64'd1;
        f        = '0;

        case (pt)
            CAP_TIME, CAP_MONITOR: begin
                f.revokable = ct == pt && (pt != CAP_TIME || p.tag == c.tag)
                              && spans(64'(p.low), 64'(p.high), 64'(c.low), 64'(c.high));
            end
            CAP_MEMORY: begin
                if (ct == CAP_PMP) begin
                    f.revokable = spans(byte_addr(p.tag, p.low), byte_addr(p.tag, p.high),
                                        pmp_base, pmp_end);
                end else begin
                    f.revokable = ct == CAP_MEMORY && p.tag == c.tag
                                  && spans(64'(p.low), 64'(p.high), 64'(c.low), 64'(c.high));
                end
            end
            CAP_CHANNEL: begin
                if (ct == CAP_SOCKET) begin
                    f.revokable = spans(64'(p.low), 64'(p.high), 64'(c.low), chan_end);
                end else begin
                    f.revokable = ct == CAP_CHANNEL
                                  && spans(64'(p.low), 64'(p.high), 64'(c.low), 64'(c.high));
                end
            end
            // A server socket revokes client sockets of its channel, whatever the child type.
            CAP_SOCKET: f.revokable = p.tag == '0 && c.tag != '0 && p.low == c.low;
            default:    f.revokable = 1'b0;
        endcase

        case (pt)
            CAP_TIME: begin
                f.derivable = ct == CAP_TIME && p.tag == c.tag && p.mark == c.low
                              && c.high <= p.high;
            end
            CAP_MEMORY: begin
                if (ct == CAP_PMP) begin
                    f.derivable = spans(byte_addr(p.tag, p.mark), byte_addr(p.tag, p.high),
                                        pmp_base, pmp_end)
                                  && subset(64'(c.bits), 64'(p.bits));
                end else begin
                    f.derivable = ct == CAP_MEMORY && p.tag == c.tag
                                  && spans(64'(p.mark), 64'(p.high), 64'(c.low), 64'(c.high))
                                  && subset(64'(c.bits), 64'(p.bits));
                end
            end
            CAP_MONITOR: begin
                f.derivable = ct == CAP_MONITOR
                              && spans(64'(p.mark), 64'(p.high), 64'(c.low), 64'(c.high));
            end
            CAP_CHANNEL: begin
                if (ct == CAP_SOCKET) begin
                    f.derivable = c.tag == '0
                                  && spans(64'(p.mark), 64'(p.high), 64'(c.low), chan_end);
                end else begin
                    f.derivable = ct == CAP_CHANNEL
                                  && spans(64'(p.mark), 64'(p.high), 64'(c.low), 64'(c.high));
                end
            end
            CAP_SOCKET: begin
                f.derivable = ct == CAP_SOCKET && p.low == c.low && p.tag == '0
                              && c.tag != '0 && p.mark == c.mark && p.bits == c.bits;
            end
            default: f.derivable = 1'b0;
        endcase

        case (ct)
            CAP_TIME, CAP_MEMORY, CAP_MONITOR, CAP_CHANNEL: begin
                f.child_valid = c.low == c.mark && c.low < c.high;
            end
            CAP_PMP: f.child_valid = c.mark == '0 && c.high == '0;
            // Every mode bit counts, so a mode above the 8-bit mask is never valid.
            CAP_SOCKET: f.child_valid = subset(64'(c.bits), 64'(perm_m))
                                        && subset(64'(c.mark), 64'(mode_m));
            default: f.child_valid = 1'b0;
        endcase
        return f;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 40) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_flags    want;
        t_flags    got;
        t_cap_data p;
        t_cap_data c;
        if (!i_rst_n) begin
            flags_due.delete();
            perm_mask = PERM_MASK_RST;
            mode_mask = MODE_MASK_RST;
        end else begin
            // Results are taken before pairs so that an early result cannot hide behind a push.
            if (i_m_tvalid && i_m_tready) begin
                got = t_flags'(i_m_tdata[2:0]);
                if (flags_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no pair outstanding",
                                              result_no));
                end else begin
                    want = flags_due.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        if (got[i] !== want[i]) begin
                            report_mismatch($sformatf("result %0d %s: expected %0b, got %b",
                                                      result_no, flag_name[i], want[i],
                                                      got[i]));
                        end
                    end
                end
                result_no++;
            end
            if (i_s_tvalid && i_s_tready) begin
                p = t_cap_data'(i_s_tdata[CAP_W-1:0]);
                c = t_cap_data'(i_s_tdata[2*CAP_W-1:CAP_W]);
                flags_due.push_back(relation_flags(t_cap_type'(i_s_tuser[TYPE_W-1:0]),
                                                   t_cap_type'(i_s_tuser[2*TYPE_W-1:TYPE_W]),
                                                   p, c, perm_mask, mode_mask));
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_idx))
                    CFG_SOCKET_PERM: perm_mask = i_cfg_data;
                    CFG_SOCKET_MODE: mode_mask = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= flags_due.size();
    end

endmodule

>>> tb/tb.sv
// Top of the testbench: clock, reset, pair stimulus, socket mask settings and the verdict.
`timescale 1ns / 1ps

module tb;
    import crc_pkg::*;

    localparam logic [FIELD_W-1:0] MAX54 = '1;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // Fields from bit 0 up: parent low, mark, high, tag, bits, then the same for the child.
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
    // Fields from bit 0 up: parent_type, child_type.
    logic [TUSER_IN_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Fields from bit 0 up: revokable, derivable, child_valid.
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [0:0]             i_cfg_idx     = CFG_SOCKET_PERM;
    logic [MASK_W-1:0]      i_cfg_data    = '0;

    int  pending_flags;
    int  flag_errors;
    // Policy flags for the random idle bursts on the two sides.
    bit  gaps_on  = 1'b0;
    bit  stall_on = 1'b0;

    capability_relation_check_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // The checker watches both streams and the mask writes on its own.
    cap_relation_monitor flags_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pending  (pending_flags),
        .o_errors   (flag_errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A generous ceiling: a correct run needs only a small fraction of this time.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: ready stays high for a random stretch, then may drop for a random burst while
    // stalling is enabled. Clock edges always lie between consecutive drives.
    initial begin
        @(posedge i_clk);
        forever begin
            if (stall_on && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    function automatic logic [FIELD_W-1:0] any54();
        return FIELD_W'({$urandom, $urandom});
    endfunction

    function automatic t_cap_data cap(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] mk,
                                      input logic [FIELD_W-1:0] hi, input logic [TAG_W-1:0] tg,
                                      input logic [BITS_W-1:0] bt);
        return '{bits: bt, tag: tg, high: hi, mark: mk, low: lo};
    endfunction

    function automatic t_cap_data any_cap();
        return cap(any54(), any54(), any54(), $urandom, 8'($urandom));
    endfunction

    // Presents one pair and holds it until the transfer completes. The valid is left high
    // so that back-to-back pairs follow without a bubble; a gap lowers it first.
    task automatic send_pair(input t_cap_type pt, input t_cap_type ct,
                             input t_cap_data p, input t_cap_data c);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_IN_W'({c, p});
        s_axis_tuser  <= {ct, pt};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stops the sender and waits for every outstanding result.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_flags != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Both masks are written back to back while the block is empty.
    task automatic set_socket_masks(input logic [MASK_W-1:0] perm, input logic [MASK_W-1:0] mode);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SOCKET_PERM;
        i_cfg_data <= perm;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SOCKET_MODE;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Builds a pair whose child is placed in or near the parent's range, so that the flags
    // are often set; a random tweak afterwards probes the boundaries.
    task automatic gen_related(output t_cap_type pt, output t_cap_type ct,
                               output t_cap_data p, output t_cap_data c);
        logic [FIELD_W-1:0] room;
        logic [FIELD_W-1:0] off;
        logic [63:0]        region;
        int unsigned        sz;
        pt = t_cap_type'($urandom_range(0, 7));
        ct = pt;
        p  = any_cap();
        c  = any_cap();
        // Mostly low ranges, sometimes right below the top of the field.
        p.low  = ($urandom_range(0, 3) == 0) ? MAX54 - FIELD_W'($urandom_range(100, 255))
                                             : FIELD_W'($urandom_range(0, 1 << 20));
        p.mark = p.low + FIELD_W'($urandom_range(0, 32));
        p.high = p.mark + FIELD_W'($urandom_range(1, 64));
        p.tag  = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : 32'($urandom);
        room   = p.high - p.mark;
        off    = ($urandom_range(0, 1) == 0) ? '0 : FIELD_W'($urandom_range(0, 32'(room) - 1));
        c.low  = p.mark + off;
        c.high = c.low + FIELD_W'($urandom_range(1, 32'(p.high - c.low)));
        c.mark = ($urandom_range(0, 4) == 0) ? p.low : c.low;
        c.tag  = ($urandom_range(0, 4) == 0) ? 32'($urandom) : p.tag;
        c.bits = p.bits & 8'($urandom);

        case (pt)
            CAP_MEMORY: begin
                // A PMP child gets a NAPOT region aligned down from a block in the parent's free range.
                if ($urandom_range(0, 1) == 0) begin
                    ct     = CAP_PMP;
                    p.tag  = 32'($urandom_range(0, 255));
                    sz     = $urandom_range(0, 12);
                    region = (64'(p.tag) << TAG_SHIFT_DEF) + (64'(c.low) << BLOCK_SHIFT_DEF);
                    region &= ~((64'd1 << (sz + 3)) - 64'd1);
                    c.low  = FIELD_W'((region >> 2) | ((64'd1 << sz) - 64'd1));
                    c.mark = ($urandom_range(0, 4) == 0) ? FIELD_W'(1) : '0;
                    c.high = ($urandom_range(0, 4) == 0) ? FIELD_W'($urandom_range(1, 15)) : '0;
                end
            end
            CAP_CHANNEL: begin
                if ($urandom_range(0, 1) == 0) begin
                    ct     = CAP_SOCKET;
                    c.tag  = ($urandom_range(0, 1) == 0) ? '0 : 32'($urandom_range(1, 1000));
                    c.mark = FIELD_W'($urandom_range(0, 3));
                    c.bits = 8'($urandom_range(0, 15));
                end
            end
            CAP_SOCKET: begin
                // Server parent, mostly with tag zero, and a client child on the same channel.
                if ($urandom_range(0, 5) == 0) ct = t_cap_type'($urandom_range(0, 7));
                p.tag  = ($urandom_range(0, 4) == 0) ? 32'($urandom) : '0;
                c.tag  = ($urandom_range(0, 4) == 0) ? '0 : 32'($urandom_range(1, 255));
                c.low  = p.low;
                p.mark = ($urandom_range(0, 7) == 0) ? any54() : FIELD_W'($urandom_range(0, 15));
                c.mark = p.mark;
                p.bits = 8'($urandom_range(0, 31));
                c.bits = p.bits;
            end
            CAP_NONE, CAP_PMP, CAP_PATH: begin
                ct = t_cap_type'($urandom_range(0, 7));
                if (ct == CAP_PMP && $urandom_range(0, 1) == 0) begin
                    c.mark = '0;
                    c.high = '0;
                end
            end
            default: ;
        endcase

        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0: c.low  = c.low - FIELD_W'(1);
                1: c.high = c.high + FIELD_W'(1);
                2: c.mark = c.mark + FIELD_W'(1);
                3: p.mark = p.mark + FIELD_W'(1);
                4: c.tag  = c.tag ^ (32'd1 << $urandom_range(0, 31));
                default: c.bits = c.bits ^ (8'd1 << $urandom_range(0, 7));
            endcase
        end
    endtask

    initial begin
        t_cap_type pt;
        t_cap_type ct;
        t_cap_data p;
        t_cap_data c;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gaps_on  = 1'b1;
        stall_on = 1'b1;

        // Directed pairs under the reset masks (permission 0x0F, mode 0x03).
        send_pair(CAP_NONE, CAP_NONE, cap(0, 0, 0, 0, 0), cap(0, 0, 0, 0, 0));
        send_pair(CAP_PATH, CAP_PATH, cap(MAX54, MAX54, MAX54, '1, '1),
                  cap(MAX54, MAX54, MAX54, '1, '1));
        // Time: exact fit, foreign hart, and a child that runs one past the end.
        send_pair(CAP_TIME, CAP_TIME, cap(10, 20, 100, 5, 0), cap(20, 20, 100, 5, 0));
        send_pair(CAP_TIME, CAP_TIME, cap(10, 20, 100, 5, 0), cap(20, 20, 100, 6, 0));
        send_pair(CAP_TIME, CAP_TIME, cap(10, 20, 100, 5, 0), cap(20, 20, 101, 5, 0));
        // Monitor: inside the range but below the free mark.
        send_pair(CAP_MONITOR, CAP_MONITOR, cap(10, 20, 100, 0, 0), cap(10, 10, 20, 0, 0));
        // Memory: rwx subset, then a permission the parent lacks.
        send_pair(CAP_MEMORY, CAP_MEMORY, cap(0, 4, 64, 3, 8'h07), cap(4, 4, 64, 3, 8'h05));
        send_pair(CAP_MEMORY, CAP_MEMORY, cap(0, 4, 64, 3, 8'h07), cap(4, 4, 64, 3, 8'h09));
        // Memory parent with a 4 KiB NAPOT child at the base of tag 1.
        send_pair(CAP_MEMORY, CAP_PMP, cap(0, 0, 16, 1, 8'h07), cap(54'h20001FF, 0, 0, 0, 8'h03));
        // Composed addresses that wrap, against a NAPOT address of all ones.
        send_pair(CAP_MEMORY, CAP_PMP, cap(MAX54, MAX54, MAX54, '1, '1), cap(MAX54, 0, 0, 0, 0));
        // PMP child with the used flag and a slot number set: not valid.
        send_pair(CAP_PMP, CAP_PMP, cap(0, 0, 0, 0, 0), cap(5, 1, 3, 0, 8'h07));
        // Channel ranges and socket children at the inner edge and just outside.
        send_pair(CAP_CHANNEL, CAP_CHANNEL, cap(0, 8, 32, 0, 0), cap(8, 8, 32, 0, 0));
        send_pair(CAP_CHANNEL, CAP_SOCKET, cap(0, 8, 32, 0, 0), cap(8, 1, 0, 0, 8'h03));
        send_pair(CAP_CHANNEL, CAP_SOCKET, cap(0, 8, 32, 0, 0), cap(31, 1, 0, 9, 8'h03));
        send_pair(CAP_CHANNEL, CAP_SOCKET, cap(0, 8, 32, 0, 0), cap(32, 0, 0, 0, 0));
        // Socket server to client, and revocation of a child of another type.
        send_pair(CAP_SOCKET, CAP_SOCKET, cap(7, 2, 0, 0, 8'h03), cap(7, 2, 0, 4, 8'h03));
        send_pair(CAP_SOCKET, CAP_MEMORY, cap(7, 2, 0, 0, 8'h03), cap(7, 2, 9, 1, 8'h03));
        // Socket children with a mode bit far above the mask, and a permission above it.
        send_pair(CAP_SOCKET, CAP_SOCKET, cap(0, 0, 0, 0, 0), cap(0, 54'h20_0000_0000_0000, 0, 1, 0));
        send_pair(CAP_SOCKET, CAP_SOCKET, cap(0, 0, 0, 0, 0), cap(0, 3, 0, 1, 8'h10));
        // Empty child range and a child whose mark is not at its start.
        send_pair(CAP_TIME, CAP_TIME, cap(0, 5, 10, 0, 0), cap(5, 5, 5, 0, 0));
        send_pair(CAP_MONITOR, CAP_CHANNEL, cap(0, 5, 10, 0, 0), cap(5, 6, 9, 0, 0));
        // Parents that never revoke or derive, with children that are valid.
        send_pair(CAP_NONE, CAP_TIME, cap(0, 0, MAX54, 0, 0), cap(1, 1, 2, 0, 0));
        send_pair(CAP_PMP, CAP_MEMORY, cap(0, 0, MAX54, 0, 8'hFF), cap(1, 1, 2, 0, 8'h07));
        send_pair(CAP_PATH, CAP_SOCKET, cap(0, 0, 0, 0, 0), cap(0, 1, 0, 1, 8'h01));

        // Random phases, each under its own socket masks; the extremes come first.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_socket_masks(8'h00, 8'h00);
                1: set_socket_masks(8'hFF, 8'hFF);
                2: set_socket_masks(8'($urandom), 8'($urandom));
                3: set_socket_masks(PERM_MASK_RST, MODE_MASK_RST);
                4: set_socket_masks(8'($urandom), 8'($urandom));
                default: set_socket_masks(8'hFF, 8'h00);
            endcase
            for (int n = 0; n < 225; n++) begin
                if (phase == 5) begin
                    // Full rate on both sides for the closing stretch.
                    gaps_on  = 1'b0;
                    stall_on = 1'b0;
                end else if (n % 45 == 0) begin
                    gaps_on  = $urandom_range(0, 3) != 0;
                    stall_on = $urandom_range(0, 3) != 0;
                end
                // Once mid-phase the sender holds off until the block has emptied.
                if (phase == 2 && n == 110) drain();
                if ($urandom_range(0, 3) == 0) begin
                    pt = t_cap_type'($urandom_range(0, 7));
                    ct = t_cap_type'($urandom_range(0, 7));
                    p  = any_cap();
                    c  = any_cap();
                end else begin
                    gen_related(pt, ct, p, c);
                end
                send_pair(pt, ct, p, c);
            end
        end

        // Wait out every outstanding result, then idle on to catch stray transfers.
        drain();
        repeat (6) @(posedge i_clk);
        if (flag_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/crc_pkg.sv
rtl/crc_addr.sv
rtl/crc_rules.sv
rtl/capability_relation_check_top.sv
tb/cap_relation_monitor.sv
tb/tb.sv
